// File: design/telnet_iac_refuser_line_assembler_top_defines.svh
// Assertion macros shared by the checker files of the telnet line assembler.
// Expects clk and rst_n in the scope where the macros are used.
`ifndef TELNET_IAC_REFUSER_LINE_ASSEMBLER_TOP_DEFINES_SVH
`define TELNET_IAC_REFUSER_LINE_ASSEMBLER_TOP_DEFINES_SVH

// Checked only outside reset.
`define TIAP_ASSERT_RUN(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define TIAP_ASSERT_ALL(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/tiap_pkg.sv
// Package for the telnet line assembler: byte codes, parser modes,
// result kinds and the group record passed between parser, queue and expander.
package tiap_pkg;

  localparam int LINE_LEN   = 80;
  localparam int POS_W      = 7;
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  localparam logic [7:0] CH_NL  = 8'h0a;
  localparam logic [7:0] CH_CR  = 8'h0d;
  localparam logic [7:0] B_IAC  = 8'd255;
  localparam logic [7:0] B_WILL = 8'd251;
  localparam logic [7:0] B_WONT = 8'd252;
  localparam logic [7:0] B_DO   = 8'd253;
  localparam logic [7:0] B_DONT = 8'd254;

  localparam logic [1:0] KIND_REPLY = 2'd0;
  localparam logic [1:0] KIND_CHAR  = 2'd1;
  localparam logic [1:0] KIND_EOL   = 2'd2;

  typedef enum logic [2:0] {
    MODE_NORMAL = 3'd0,
    MODE_IAC    = 3'd1,
    MODE_WILL   = 3'd2,
    MODE_WONT   = 3'd3,
    MODE_DO     = 3'd4,
    MODE_DONT   = 3'd5
  } mode_t;

  typedef enum logic [1:0] {
    GRP_CHAR   = 2'd0,
    GRP_EOL    = 2'd1,
    GRP_REFUSE = 2'd2
  } grp_kind_t;

  // One entry per input byte that produces output; a refusal expands to three beats.
  typedef struct packed {
    grp_kind_t        kind;
    logic [7:0]       data;
    logic [7:0]       verb;
    logic [POS_W-1:0] len;
  } grp_t;

endpackage

// File: design/tiap_parser.sv
// Telnet parser: IAC state machine plus line position counter.
// Produces one group record per input byte that yields output. Uses tiap_pkg.
module tiap_parser (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_fire,
  input  logic [7:0]         rx_byte,
  output logic               grp_push,
  output tiap_pkg::grp_t     grp
);

  localparam logic [tiap_pkg::POS_W-1:0] POS_LIMIT =
    tiap_pkg::POS_W'(tiap_pkg::LINE_LEN - 1);

  tiap_pkg::mode_t             mode_r, mode_nxt;
  logic [tiap_pkg::POS_W-1:0]  pos_r, pos_nxt;
  logic                        emit;
  logic                        is_data;

  // next mode
  always_comb begin
    mode_nxt = tiap_pkg::MODE_NORMAL;
    unique case (mode_r)
      tiap_pkg::MODE_IAC: begin
        if (rx_byte == tiap_pkg::B_WILL)      mode_nxt = tiap_pkg::MODE_WILL;
        else if (rx_byte == tiap_pkg::B_WONT) mode_nxt = tiap_pkg::MODE_WONT;
        else if (rx_byte == tiap_pkg::B_DO)   mode_nxt = tiap_pkg::MODE_DO;
        else if (rx_byte == tiap_pkg::B_DONT) mode_nxt = tiap_pkg::MODE_DONT;
        else                                  mode_nxt = tiap_pkg::MODE_NORMAL;
      end
      tiap_pkg::MODE_WILL, tiap_pkg::MODE_WONT,
      tiap_pkg::MODE_DO, tiap_pkg::MODE_DONT: begin
        mode_nxt = tiap_pkg::MODE_NORMAL;
      end
      default: begin
        mode_nxt = (rx_byte == tiap_pkg::B_IAC) ? tiap_pkg::MODE_IAC
                                                : tiap_pkg::MODE_NORMAL;
      end
    endcase
  end

  // outputs and line position
  always_comb begin
    emit     = 1'b0;
    is_data  = 1'b0;
    pos_nxt  = pos_r;
    grp.kind = tiap_pkg::GRP_CHAR;
    grp.data = rx_byte;
    grp.verb = tiap_pkg::B_DONT;
    grp.len  = '0;
    unique case (mode_r)
      // IAC IAC is a literal 255, which is rx_byte itself
      tiap_pkg::MODE_IAC: begin
        is_data = (rx_byte == tiap_pkg::B_IAC);
      end
      tiap_pkg::MODE_WILL, tiap_pkg::MODE_WONT: begin
        emit     = 1'b1;
        grp.kind = tiap_pkg::GRP_REFUSE;
        grp.verb = tiap_pkg::B_DONT;
      end
      tiap_pkg::MODE_DO, tiap_pkg::MODE_DONT: begin
        emit     = 1'b1;
        grp.kind = tiap_pkg::GRP_REFUSE;
        grp.verb = tiap_pkg::B_WONT;
      end
      default: begin
        is_data = (rx_byte != tiap_pkg::B_IAC);
      end
    endcase

    if (is_data && (rx_byte != tiap_pkg::CH_CR)) begin
      emit = 1'b1;
      // at the limit the arriving byte is dropped and closes the line
      if ((rx_byte == tiap_pkg::CH_NL) || (pos_r >= POS_LIMIT)) begin
        grp.kind = tiap_pkg::GRP_EOL;
        grp.len  = pos_r;
        pos_nxt  = '0;
      end else begin
        grp.kind = tiap_pkg::GRP_CHAR;
        pos_nxt  = pos_r + 1'b1;
      end
    end
  end

  assign grp_push = in_fire & emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= tiap_pkg::MODE_NORMAL;
      pos_r  <= '0;
    end else if (in_fire) begin
      mode_r <= mode_nxt;
      pos_r  <= pos_nxt;
    end
  end

endmodule

// File: design/tiap_group_fifo.sv
// Small register queue of group records between parser and expander.
// Uses tiap_pkg for depth and record type.
module tiap_group_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  tiap_pkg::grp_t push_grp,
  input  logic           pop,
  output logic           full,
  output logic           head_valid,
  output tiap_pkg::grp_t head_grp
);

  tiap_pkg::grp_t                   mem_r [tiap_pkg::FIFO_DEPTH];
  logic [tiap_pkg::PTR_W-1:0]       wr_ptr_r, rd_ptr_r;
  logic [tiap_pkg::CNT_W-1:0]       count_r, count_nxt;

  assign full       = (count_r == tiap_pkg::CNT_W'(tiap_pkg::FIFO_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_grp   = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_grp;
  end

endmodule

// File: design/tiap_expander.sv
// Turns the head group record into result beats: one for a character or
// end of line, three for a refusal. Uses tiap_pkg.
module tiap_expander (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           head_valid,
  input  tiap_pkg::grp_t head_grp,
  input  logic           out_ready,
  output logic           pop,
  output logic           out_valid,
  output logic [1:0]     out_kind,
  output logic [7:0]     out_byte,
  output logic [6:0]     out_line_length,
  output logic           out_last
);

  logic [1:0] sub_r, sub_nxt;
  logic       beat_fire;

  always_comb begin
    out_kind        = tiap_pkg::KIND_CHAR;
    out_byte        = head_grp.data;
    out_line_length = '0;
    out_last        = 1'b1;
    case (head_grp.kind)
      tiap_pkg::GRP_EOL: begin
        out_kind        = tiap_pkg::KIND_EOL;
        out_byte        = '0;
        out_line_length = head_grp.len;
      end
      tiap_pkg::GRP_REFUSE: begin
        out_kind = tiap_pkg::KIND_REPLY;
        out_last = (sub_r == 2'd2);
        case (sub_r)
          2'd0:    out_byte = tiap_pkg::B_IAC;
          2'd1:    out_byte = head_grp.verb;
          default: out_byte = head_grp.data;
        endcase
      end
      default: begin
        out_kind = tiap_pkg::KIND_CHAR;
      end
    endcase
  end

  assign out_valid = head_valid;
  assign beat_fire = out_valid & out_ready;
  assign pop       = beat_fire & out_last;
  assign sub_nxt   = pop ? 2'd0 : (sub_r + 1'b1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sub_r <= '0;
    end else if (beat_fire) begin
      sub_r <= sub_nxt;
    end
  end

endmodule

// File: design/telnet_iac_refuser_line_assembler_top.sv
// Channel | handshake            | payload
// in      | in_valid / in_ready  | in_rx_byte
// out     | out_valid / out_ready| out_kind, out_byte, out_line_length, out_last
//
// One byte accepted per cycle; each result group is queued and leaves on the
// next cycle at the earliest, one beat per ready cycle (refusals take three beats).
// in_ready drops only when the four-entry group queue is full.
// Synchronous active-low reset returns the parser to data mode, position zero,
// and empties the queue; no clearing pass.
// Top level; uses tiap_pkg, tiap_parser, tiap_group_fifo and tiap_expander.
module telnet_iac_refuser_line_assembler_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_kind,
  output logic [7:0] out_byte,
  output logic [6:0] out_line_length,
  output logic       out_last
);

  logic           in_fire;
  logic           grp_push;
  tiap_pkg::grp_t grp;
  logic           fifo_full;
  logic           head_valid;
  tiap_pkg::grp_t head_grp;
  logic           pop;

  assign in_ready = ~fifo_full;
  assign in_fire  = in_valid & in_ready;

  tiap_parser u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .rx_byte  (in_rx_byte),
    .grp_push (grp_push),
    .grp      (grp)
  );

  tiap_group_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (grp_push),
    .push_grp   (grp),
    .pop        (pop),
    .full       (fifo_full),
    .head_valid (head_valid),
    .head_grp   (head_grp)
  );

  tiap_expander u_expander (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_valid      (head_valid),
    .head_grp        (head_grp),
    .out_ready       (out_ready),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_kind        (out_kind),
    .out_byte        (out_byte),
    .out_line_length (out_line_length),
    .out_last        (out_last)
  );

endmodule

// File: design/tiap_checker.sv
// Port-level checker for the telnet line assembler, bound to the top level.
// Uses tiap_pkg and the assertion macros of the top-level defines header.
`include "telnet_iac_refuser_line_assembler_top_defines.svh"

module tiap_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_kind,
  input logic [7:0] out_byte,
  input logic [6:0] out_line_length,
  input logic       out_last
);

  logic [17:0] out_beat;
  logic        out_stall;
  logic        is_reply;
  logic        reply_mid;
  logic        is_eol;
  logic        eol_ok;

  assign out_beat  = {out_kind, out_byte, out_line_length, out_last};
  assign out_stall = out_valid && !out_ready;
  assign is_reply  = (out_kind == tiap_pkg::KIND_REPLY);
  // a refusal beat other than the third one was just taken
  assign reply_mid = out_valid && out_ready && is_reply && !out_last;
  assign is_eol    = (out_kind == tiap_pkg::KIND_EOL);
  assign eol_ok    = out_last && (out_byte == 8'd0) &&
                     (out_line_length <= 7'(tiap_pkg::LINE_LEN - 1));

  `TIAP_ASSERT_ALL(a_reset_empty, !rst_n |=> !out_valid && in_ready, "results pending after reset")

  `TIAP_ASSERT_RUN(a_out_hold, out_stall |=> out_valid && $stable(out_beat), "stalled beat changed")

  `TIAP_ASSERT_RUN(a_reply_cont, reply_mid |=> out_valid && is_reply, "refusal beats broken up")

  `TIAP_ASSERT_RUN(a_eol_shape, out_valid && is_eol |-> eol_ok, "malformed end of line beat")

endmodule

bind telnet_iac_refuser_line_assembler_top tiap_checker u_tiap_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_kind        (out_kind),
  .out_byte        (out_byte),
  .out_line_length (out_line_length),
  .out_last        (out_last)
);

// File: tb/tb_telnet_iac_refuser_line_assembler_top.sv
// Self-checking testbench for telnet_iac_refuser_line_assembler_top: random byte
// streams with option negotiation, literal IACs and line-limit lines, checked against
// an in-bench parser model. Depends on tiap_pkg and the top-level RTL.
module tb_telnet_iac_refuser_line_assembler_top;
  import tiap_pkg::*;

  localparam int RANDOM_ITEMS   = 410;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = 20;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic [6:0] len;
    logic       is_last;
  } line_result_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_rx_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] out_kind;
  logic [7:0] out_byte;
  logic [6:0] out_line_length;
  logic       out_last;

  logic [7:0]   rx_pending[$];
  line_result_t expected_beats[$];

  // parser state mirrored in the bench
  mode_t      tel_mode = MODE_NORMAL;
  logic [6:0] line_pos = '0;

  int total_bytes;
  int accepted_bytes = 0;
  int fail_count = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  int gap_left = 0;
  logic [15:0] ready_pattern = 16'hffff;
  logic [3:0]  ready_phase = '0;

  telnet_iac_refuser_line_assembler_top DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_kind        (out_kind),
    .out_byte        (out_byte),
    .out_line_length (out_line_length),
    .out_last        (out_last)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic void push_result(logic [1:0] kind, logic [7:0] data, logic [6:0] len,
                                      logic is_last);
    line_result_t r;
    r.kind    = kind;
    r.data    = data;
    r.len     = len;
    r.is_last = is_last;
    expected_beats.push_back(r);
  endfunction

  function automatic void assemble_char(logic [7:0] c);
    if (c == CH_CR) return;
    if (c == CH_NL || line_pos >= LINE_LEN - 1) begin
      push_result(KIND_EOL, 8'h00, line_pos, 1'b1);
      line_pos = '0;
    end else begin
      push_result(KIND_CHAR, c, '0, 1'b1);
      line_pos = line_pos + 7'd1;
    end
  endfunction

  function automatic void queue_refusal(logic [7:0] verb, logic [7:0] opt);
    push_result(KIND_REPLY, B_IAC, '0, 1'b0);
    push_result(KIND_REPLY, verb, '0, 1'b0);
    push_result(KIND_REPLY, opt, '0, 1'b1);
  endfunction

  function automatic void predict_rx_byte(logic [7:0] c);
    mode_t m;
    m = tel_mode;
    tel_mode = MODE_NORMAL;
    case (m)
      MODE_IAC: begin
        if (c == B_IAC) assemble_char(c);
        else if (c == B_WILL) tel_mode = MODE_WILL;
        else if (c == B_WONT) tel_mode = MODE_WONT;
        else if (c == B_DO) tel_mode = MODE_DO;
        else if (c == B_DONT) tel_mode = MODE_DONT;
      end
      MODE_WILL, MODE_WONT: queue_refusal(B_DONT, c);
      MODE_DO, MODE_DONT: queue_refusal(B_WONT, c);
      default: begin
        if (c == B_IAC) tel_mode = MODE_IAC;
        else assemble_char(c);
      end
    endcase
  endfunction

  function automatic logic [7:0] text_byte();
    logic [7:0] b;
    if ($urandom_range(0, 4) != 0) return 8'($urandom_range(8'h20, 8'h7e));
    do b = 8'($urandom); while (b == CH_NL || b == B_IAC);
    return b;
  endfunction

  // sender: bursts of random length separated by random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid   <= 1'b0;
      in_rx_byte <= 8'h00;
      tel_mode   = MODE_NORMAL;
      line_pos   = '0;
    end else begin
      if (in_valid && in_ready) begin
        predict_rx_byte(in_rx_byte);
        accepted_bytes++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          in_valid <= 1'b0;
          gap_left--;
        end else if (rx_pending.size() > 0) begin
          in_valid   <= 1'b1;
          in_rx_byte <= rx_pending.pop_front();
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: walks a 16-bit ready pattern, reloaded at each wrap
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready   <= ready_pattern[ready_phase];
      ready_phase <= ready_phase + 4'd1;
      if (ready_phase == 4'hf)
        ready_pattern <= ($urandom_range(0, 3) == 0) ? 16'hffff : (16'($urandom) | 16'h0001);
    end
  end

  always @(posedge clk) begin : result_check
    line_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_beats.size() == 0) begin
        $error("result beat with nothing expected: kind %0d byte %0h", out_kind, out_byte);
        fail_count++;
      end else begin
        want = expected_beats.pop_front();
        if (out_kind !== want.kind) begin
          $error("out_kind: expected %0d, got %0d", want.kind, out_kind);
          fail_count++;
        end
        if (out_byte !== want.data) begin
          $error("out_byte: expected %0h, got %0h", want.data, out_byte);
          fail_count++;
        end
        if (out_line_length !== want.len) begin
          $error("out_line_length: expected %0d, got %0d", want.len, out_line_length);
          fail_count++;
        end
        if (out_last !== want.is_last) begin
          $error("out_last: expected %0d, got %0d", want.is_last, out_last);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int n;
    int seg;
    int limit_lines;
    // directed: short lines, empty line, byte extremes, CR, literal IAC,
    // all four negotiation verbs, swallowed commands
    rx_pending = '{8'h48, 8'h69, CH_NL, CH_NL, 8'h00, 8'h7f, 8'h80, CH_CR,
                   B_IAC, B_IAC, B_IAC, B_WILL, 8'h01, B_IAC, B_WONT, 8'hff,
                   B_IAC, B_DO, 8'h00, B_IAC, B_DONT, 8'h18, B_IAC, 8'hf1,
                   B_IAC, CH_NL, CH_NL};
    limit_lines = 0;
    while (rx_pending.size() < RANDOM_ITEMS) begin
      seg = $urandom_range(0, 9);
      // line-limit lines at fixed points: ends on plain char, newline, literal IAC
      if (rx_pending.size() > 60 + limit_lines * 110 && limit_lines < 3) begin
        rx_pending.push_back(CH_NL);
        rx_pending.push_back(CH_NL);
        for (int i = 0; i < LINE_LEN - 1; i++)
          rx_pending.push_back(8'($urandom_range(8'h20, 8'hfe)));
        if ($urandom_range(0, 1) == 0) rx_pending.push_back(CH_CR);
        case (limit_lines)
          0: rx_pending.push_back(8'h7a);
          1: rx_pending.push_back(CH_NL);
          default: begin
            rx_pending.push_back(B_IAC);
            rx_pending.push_back(B_IAC);
          end
        endcase
        limit_lines++;
      end else if (seg <= 3) begin
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 30) : $urandom_range(0, 12);
        for (int i = 0; i < n; i++)
          rx_pending.push_back(($urandom_range(0, 15) == 0) ? CH_CR : text_byte());
        if ($urandom_range(0, 2) == 0) rx_pending.push_back(CH_CR);
        rx_pending.push_back(CH_NL);
      end else if (seg == 4) begin
        rx_pending.push_back(B_IAC);
        rx_pending.push_back(B_IAC);
      end else if (seg <= 6) begin
        rx_pending.push_back(B_IAC);
        rx_pending.push_back(8'($urandom_range(B_WILL, B_DONT)));
        rx_pending.push_back(8'($urandom));
      end else if (seg == 7) begin
        rx_pending.push_back(B_IAC);
        rx_pending.push_back(8'($urandom));
      end else begin
        // noise, may leave a broken command sequence behind
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++)
          rx_pending.push_back(($urandom_range(0, 3) == 0) ? B_IAC : 8'($urandom));
      end
    end
    total_bytes = rx_pending.size();

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (accepted_bytes < total_bytes) @(posedge clk);
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
